/* design/smwc_pkg.sv */
// ----------------------------------------------------------------------------
// smwc_pkg: shared definitions for the soil moisture watering controller
// Widths, codes, register reset values, controller types and the reciprocal
// table that the averaging divide uses.
// ----------------------------------------------------------------------------
package smwc_pkg;

	// Reading channel.
	localparam int SENSOR_COUNT = 4;
	localparam int SENSOR_W     = 14;
	localparam int MASK_W       = SENSOR_COUNT;
	localparam int FULL_SCALE   = 10000;

	// Accumulator and count widths follow from the number of readings.
	localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
	localparam int SUM_W = $clog2(SENSOR_COUNT * FULL_SCALE + 1);
	localparam int M_W   = $clog2(SENSOR_COUNT * FULL_SCALE + SENSOR_COUNT / 2 + 1);
	localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	// Division by the reading count is a multiply by a rounded-up reciprocal.
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	// Result fields.
	localparam int AVG_W  = 14;
	localparam int USED_W = 3;

	// Configuration registers.
	localparam int THR_W      = 7;
	localparam int INTV_W     = 16;
	localparam int COOL_W     = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int HUND_W     = 14;

	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(30);
	localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(10);
	localparam logic              AUTO_RESET = 1'b1;
	localparam logic [COOL_W-1:0] COOL_RESET = COOL_W'(3600);

	// Seconds since the last action saturate at all ones.
	localparam logic [COOL_W-1:0] SINCE_MAX = '1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_TOGGLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD    = 2'd0,
		CFG_OFF_INTERVAL = 2'd1,
		CFG_AUTO_ENABLE  = 2'd2,
		CFG_COOLDOWN     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_EXEC
	} st_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic divide;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic evt_is_sample;
	} dp_sts_t;

	// ceil(2^RECIP_SHIFT / n) for n from one to eight; exact for every
	// dividend the accumulator can produce.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (int'(n))
			1:       r = RECIP_W'(1048576);
			2:       r = RECIP_W'(524288);
			3:       r = RECIP_W'(349526);
			4:       r = RECIP_W'(262144);
			5:       r = RECIP_W'(209716);
			6:       r = RECIP_W'(174763);
			7:       r = RECIP_W'(149797);
			8:       r = RECIP_W'(131072);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/smwc_if.sv */
// ----------------------------------------------------------------------------
// smwc_if: event and result channels
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface smwc_evt_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      op;
	logic [smwc_pkg::SENSOR_W-1:0]   sensor_a;
	logic [smwc_pkg::SENSOR_W-1:0]   sensor_b;
	logic [smwc_pkg::SENSOR_W-1:0]   sensor_c;
	logic [smwc_pkg::SENSOR_W-1:0]   sensor_d;
	logic [smwc_pkg::MASK_W-1:0]     valid_mask;

	modport source (
		output valid, op, sensor_a, sensor_b, sensor_c, sensor_d, valid_mask,
		input  ready
	);
	modport sink (
		input  valid, op, sensor_a, sensor_b, sensor_c, sensor_d, valid_mask,
		output ready
	);
endinterface

interface smwc_res_if;
	logic                          valid;
	logic                          ready;
	logic [smwc_pkg::AVG_W-1:0]    average_moisture;
	logic [smwc_pkg::USED_W-1:0]   used_count;
	logic                          pump_on;
	logic                          relay_level;
	logic                          alert;
	logic                          auto_started;

	modport source (
		output valid, average_moisture, used_count, pump_on, relay_level, alert,
		       auto_started,
		input  ready
	);
	modport sink (
		input  valid, average_moisture, used_count, pump_on, relay_level, alert,
		       auto_started,
		output ready
	);
endinterface

/* design/soil_moisture_watering_controller_unit.sv */
// ----------------------------------------------------------------------------
// soil_moisture_watering_controller_unit: soil moisture watering controller
// Averages sets of moisture readings, decides on watering or an alert under
// a cooldown, and times the pump off with one-second ticks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Transaction carries
//   -------  ---------  --------------------------------------------------------
//   evt      in         op, four readings and their valid mask
//   res      out        average, reading count, pump and relay state, flags
//   cfg      in         write enable, register index, write data (no handshake)
//
// A reading set passes through the accept step, one accumulator step per
// reading, the reciprocal multiply and the commit. Ticks, button toggles and
// the unused op go from the accept step straight to the commit. One event is
// in flight at a time; the next is taken once the previous result sits in
// the output register, so a stalled result costs nothing until the following
// commit. Reset is asynchronous and returns the pump to off, the cooldown to
// elapsed and the configuration and control registers to their defaults; the
// reading and result registers are not reset, and there is no clearing pass.
//
module soil_moisture_watering_controller_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	smwc_evt_if.sink                         evt,
	smwc_res_if.source                       res,
	input  logic                             cfg_we,
	input  logic [smwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smwc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import smwc_pkg::*;

	// The sequencer and the datapath talk only through these two bundles.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The sequencer owns both handshakes and walks each event through its
	// steps; it waits in its commit step while the result register is full.
	smwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds configuration, pump and cooldown state, the
	// accumulator, the divide and the result payload register.
	smwc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.op               (evt.op),
		.sensor_a         (evt.sensor_a),
		.sensor_b         (evt.sensor_b),
		.sensor_c         (evt.sensor_c),
		.sensor_d         (evt.sensor_d),
		.valid_mask       (evt.valid_mask),
		.average_moisture (res.average_moisture),
		.used_count       (res.used_count),
		.pump_on          (res.pump_on),
		.relay_level      (res.relay_level),
		.alert            (res.alert),
		.auto_started     (res.auto_started)
	);

endmodule

/* design/smwc_dp.sv */
// ----------------------------------------------------------------------------
// smwc_dp: watering controller datapath
// Configuration registers, reading accumulator, reciprocal divide, pump and
// cooldown state, and the result register.
// ----------------------------------------------------------------------------
module smwc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smwc_pkg::dp_cmd_t                cmd,
	output smwc_pkg::dp_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [smwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [1:0]                       op,
	input  logic [smwc_pkg::SENSOR_W-1:0]    sensor_a,
	input  logic [smwc_pkg::SENSOR_W-1:0]    sensor_b,
	input  logic [smwc_pkg::SENSOR_W-1:0]    sensor_c,
	input  logic [smwc_pkg::SENSOR_W-1:0]    sensor_d,
	input  logic [smwc_pkg::MASK_W-1:0]      valid_mask,
	output logic [smwc_pkg::AVG_W-1:0]       average_moisture,
	output logic [smwc_pkg::USED_W-1:0]      used_count,
	output logic                             pump_on,
	output logic                             relay_level,
	output logic                             alert,
	output logic                             auto_started
);
	import smwc_pkg::*;

	// Configuration.
	logic [THR_W-1:0]  thr_q;
	logic [INTV_W-1:0] intv_q;
	logic              auto_q;
	logic [COOL_W-1:0] cool_q;

	// Controller state.
	logic              pump_q;
	logic [COOL_W-1:0] since_q;
	logic [INTV_W-1:0] cnt_q;

	// Item in flight.
	op_t                op_q;
	logic [SENSOR_W-1:0] sens_q [SENSOR_COUNT];
	logic [MASK_W-1:0]  mask_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   npos_q;
	logic [CNT_W-1:0]   nzero_q;
	logic [AVG_W-1:0]   avg_q;

	logic [SENSOR_W-1:0] sens_in [SENSOR_COUNT];
	logic [SENSOR_W-1:0] head_clamped;
	logic [M_W-1:0]      div_m;
	logic [M_W+RECIP_W-1:0] div_prod;
	logic [USED_W-1:0]   used;
	logic [HUND_W-1:0]   thr_hund;
	logic                low_seen;

	logic              pump_d;
	logic [COOL_W-1:0] since_d;
	logic [INTV_W-1:0] cnt_d;
	logic              alert_d;
	logic              started_d;

	assign sens_in[0] = sensor_a;
	assign sens_in[1] = sensor_b;
	assign sens_in[2] = sensor_c;
	assign sens_in[3] = sensor_d;

	assign sts.evt_is_sample = (op_t'(op) == OP_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			intv_q <= INTV_RESET;
			auto_q <= AUTO_RESET;
			cool_q <= COOL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD:    thr_q  <= cfg_data[THR_W-1:0];
				CFG_OFF_INTERVAL: intv_q <= cfg_data[INTV_W-1:0];
				CFG_AUTO_ENABLE:  auto_q <= cfg_data[0];
				CFG_COOLDOWN:     cool_q <= cfg_data[COOL_W-1:0];
				default:          ;
			endcase
		end
	end

	// Readings shift toward the head; one reading is folded in per step.
	assign head_clamped = (int'(sens_q[0]) > FULL_SCALE) ? SENSOR_W'(FULL_SCALE) : sens_q[0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(op);
			mask_q  <= valid_mask;
			sum_q   <= '0;
			npos_q  <= '0;
			nzero_q <= '0;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				sens_q[i] <= sens_in[i];
			end
		end else if (cmd.step) begin
			for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
				sens_q[i] <= sens_q[i+1];
			end
			mask_q <= mask_q >> 1;
			if (mask_q[0]) begin
				if (head_clamped != '0) begin
					sum_q  <= sum_q + SUM_W'(head_clamped);
					npos_q <= npos_q + CNT_W'(1);
				end else begin
					nzero_q <= nzero_q + CNT_W'(1);
				end
			end
		end
	end

	// Rounded average: floor((2*sum + n) / (2*n)) = floor((sum + n/2) / n).
	assign div_m    = M_W'(sum_q) + M_W'(npos_q >> 1);
	assign div_prod = (M_W+RECIP_W)'(div_m) * (M_W+RECIP_W)'(recip(npos_q));

	always_ff @(posedge clk) begin
		if (cmd.divide) begin
			avg_q <= (npos_q == '0) ? '0 : div_prod[RECIP_SHIFT +: AVG_W];
		end
	end

	assign used     = USED_W'((npos_q != '0) ? npos_q : nzero_q);
	assign thr_hund = HUND_W'(thr_q) * HUND_W'(100);
	assign low_seen = (used != '0) && (avg_q <= thr_hund) && (since_q >= cool_q);

	always_comb begin
		pump_d    = pump_q;
		since_d   = since_q;
		cnt_d     = cnt_q;
		alert_d   = 1'b0;
		started_d = 1'b0;
		case (op_q)
			OP_SAMPLE: begin
				if (low_seen) begin
					if (auto_q) begin
						if (!pump_q) begin
							pump_d    = 1'b1;
							cnt_d     = intv_q;
							started_d = 1'b1;
							since_d   = '0;
						end
					end else begin
						alert_d = 1'b1;
						since_d = '0;
					end
				end
			end
			OP_TICK: begin
				if (since_q != SINCE_MAX) begin
					since_d = since_q + COOL_W'(1);
				end
				if (pump_q) begin
					if (cnt_q <= INTV_W'(1)) begin
						pump_d = 1'b0;
						cnt_d  = '0;
					end else begin
						cnt_d = cnt_q - INTV_W'(1);
					end
				end
			end
			OP_TOGGLE: begin
				pump_d = !pump_q;
				cnt_d  = pump_q ? '0 : intv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q  <= 1'b0;
			since_q <= SINCE_MAX;
			cnt_q   <= '0;
		end else if (cmd.commit) begin
			pump_q  <= pump_d;
			since_q <= since_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			average_moisture <= (op_q == OP_SAMPLE) ? avg_q : '0;
			used_count       <= (op_q == OP_SAMPLE) ? used : '0;
			pump_on          <= pump_d;
			relay_level      <= !pump_d;
			alert            <= alert_d;
			auto_started     <= started_d;
		end
	end

endmodule

/* design/smwc_ctrl.sv */
// ----------------------------------------------------------------------------
// smwc_ctrl: watering controller sequencer
// Steps each reading set through capture, accumulation, divide and commit,
// other events from capture straight to commit, and owns both handshakes.
// ----------------------------------------------------------------------------
module smwc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  smwc_pkg::dp_sts_t sts,
	output smwc_pkg::dp_cmd_t cmd
);
	import smwc_pkg::*;

	st_t              state_q;
	st_t              state_d;
	logic [IDX_W-1:0] idx_q;
	logic             res_valid_q;
	logic             slot_free;

	// The result register can be reloaded once it is empty or being drained.
	assign slot_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		evt_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					cmd.capture = 1'b1;
					state_d     = sts.evt_is_sample ? ST_ACCUM : ST_EXEC;
				end
			end
			ST_ACCUM: begin
				cmd.step = 1'b1;
				if (int'(idx_q) == SENSOR_COUNT - 1) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.divide = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_ACCUM) begin
			idx_q <= (int'(idx_q) == SENSOR_COUNT - 1) ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule
